// ----- rtl/core/epid_pkg.sv -----
// Shared types and constants for the encoder PID speed controller.
// Depends on nothing; every other file of the block imports it.
package epid_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int SUM_WIDTH      = 24;

    localparam int ACTION_W  = 2;
    localparam int TARGET_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int SCALE_W   = 8;
    localparam int COUNT_W   = 32;
    localparam int SPEED_W   = 15;
    localparam int ERR_W     = 16;
    localparam int DUTY_W    = 8;

    localparam int OPND_W  = (SUM_WIDTH > ERR_W + 2) ? SUM_WIDTH : ERR_W + 2;
    localparam int ACC_W   = OPND_W + GAIN_W + 2;
    localparam int DELTA_W = ACC_W - GAIN_FRAC_BITS;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_PULSE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = {DUTY_W{1'b1}};

    localparam logic [ACC_W-1:0] FRAC_MASK =
        ({{(ACC_W-1){1'b0}}, 1'b1} << GAIN_FRAC_BITS) - {{(ACC_W-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [SCALE_W-1:0] speed_scale;
    } epid_cfg_t;

    typedef struct packed {
        logic                    load;
        logic                    clear_acc;
        logic signed [ACC_W-1:0] operand;
        logic [GAIN_W-1:0]       multiplier;
    } epid_mac_cmd_t;

endpackage

// ----- rtl/core/epid_if.sv -----
// Valid/ready channel interfaces for the command input and the result output.
// Depends on epid_pkg for the field widths.
interface epid_in_if import epid_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [TARGET_W-1:0] target_speed;

    modport source (output valid, output action, output target_speed, input ready);
    modport sink (input valid, input action, input target_speed, output ready);
endinterface

interface epid_out_if import epid_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    forward;
    logic [DUTY_W-1:0]       drive_pwm;
    logic [SPEED_W-1:0]      measured_speed;
    logic signed [ERR_W-1:0] speed_error;

    modport source (output valid, output forward, output drive_pwm,
                    output measured_speed, output speed_error, input ready);
    modport sink (input valid, input forward, input drive_pwm,
                  input measured_speed, input speed_error, output ready);
endinterface

// ----- rtl/core/epid_apb_regs.sv -----
// APB configuration registers: gains and speed scale.
// Depends on epid_pkg for the register map and the configuration struct.
module epid_apb_regs import epid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output epid_cfg_t             cfg
);

    epid_cfg_t              cfg_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.deriv_gain  <= '0;
            cfg_reg.speed_scale <= SCALE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  cfg_reg.deriv_gain  <= pwdata[GAIN_W-1:0];
                REG_SPEED_SCALE: cfg_reg.speed_scale <= pwdata[SCALE_W-1:0];
                default:         cfg_reg.prop_gain   <= cfg_reg.prop_gain;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PROP_GAIN:   prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.prop_gain};
            REG_INTEG_GAIN:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.integ_gain};
            REG_DERIV_GAIN:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.deriv_gain};
            REG_SPEED_SCALE: prdata = {{(APB_DATA_W-SCALE_W){1'b0}}, cfg_reg.speed_scale};
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/epid_serial_mac.sv -----
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle, shift and add.
// Depends on epid_pkg for the accumulator width and the command struct.
module epid_serial_mac import epid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  epid_mac_cmd_t           cmd,
    output logic signed [ACC_W-1:0] acc,
    output logic                    busy
);

    logic [GAIN_W-1:0]       mult_reg;
    logic signed [ACC_W-1:0] op_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign busy = (mult_reg != '0);
    assign acc  = acc_reg;
    assign acc_next = mult_reg[0] ? acc_reg + op_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= '0;
        end
        else if (cmd.load)
        begin
            mult_reg <= cmd.multiplier;
        end
        else if (busy)
        begin
            mult_reg <= mult_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= cmd.operand;
            if (cmd.clear_acc)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy)
        begin
            op_reg  <= op_reg <<< 1;
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- rtl/core/encoder_pid_motor_speed_controller_top.sv -----
// Top level of one encoder-fed incremental PID motor speed channel.
// Depends on epid_pkg, epid_if, epid_apb_regs and epid_serial_mac.
//
//   Port      Kind            Fields
//   in_ch     valid/ready in  action, target_speed
//   out_ch    valid/ready out forward, drive_pwm, measured_speed, speed_error
//   APB       config write    prop_gain, integ_gain, deriv_gain, speed_scale
//
// A pulse, clear or unused action is handled in the idle state. A control tick makes
// four passes through the bit-serial multiplier, one with speed_scale and one with
// each gain, each pass running up to the highest set bit of its multiplier.
// Reset is asynchronous and active low and needs no clearing pass.
// A result waiting in the output register does not block input; only the final
// step of the next tick waits for that register to empty.
module encoder_pid_motor_speed_controller_top import epid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    epid_in_if.sink               in_ch,
    epid_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SPEED = 8'b0000_0010,
        S_ERR   = 8'b0000_0100,
        S_PROP  = 8'b0000_1000,
        S_DERIV = 8'b0001_0000,
        S_INTEG = 8'b0010_0000,
        S_DELTA = 8'b0100_0000,
        S_DUTY  = 8'b1000_0000
    } state_t;

    localparam logic signed [DELTA_W-1:0] DELTA_HI = DELTA_W'(256);
    localparam logic signed [DELTA_W-1:0] DELTA_LO = -DELTA_W'(256);

    epid_cfg_t                   cfg;
    epid_mac_cmd_t               mac_cmd;
    logic signed [ACC_W-1:0]     mac_acc;
    logic                        mac_busy;

    state_t                      state_reg, state_next;
    logic [COUNT_W-1:0]          pulse_count_reg;
    logic [COUNT_W-1:0]          prior_count_reg;
    logic                        dir_forward_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]     prev_error_reg;
    logic [DUTY_W-1:0]           duty_reg;
    logic [SPEED_W-1:0]          mag_reg;
    logic                        sat_reg;
    logic [SPEED_W-1:0]          speed_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [DELTA_W-1:0]   delta_reg;
    logic                        out_valid_reg;
    logic                        out_forward_reg;
    logic [DUTY_W-1:0]           out_pwm_reg;
    logic [SPEED_W-1:0]          out_speed_reg;
    logic signed [ERR_W-1:0]     out_error_reg;

    logic                        in_fire;
    logic                        tick_fire;
    logic                        target_neg;
    logic                        target_pos;
    logic                        flip;
    logic [COUNT_W-1:0]          diff;
    logic [SPEED_W-1:0]          mag_next;
    logic [SPEED_W-1:0]          speed_next;
    logic signed [ERR_W:0]       err_wide;
    logic signed [ERR_W-1:0]     err_next;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic signed [ERR_W:0]       derr;
    logic signed [ACC_W-1:0]     acc_adj;
    logic signed [ACC_W-1:0]     acc_shift;
    logic signed [9:0]           delta_clip;
    logic signed [10:0]          duty_sum;
    logic [DUTY_W-1:0]           duty_next;
    logic                        out_free;

    epid_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    epid_serial_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign tick_fire   = in_fire && (in_ch.action == ACT_TICK);

    assign target_neg = in_ch.target_speed[TARGET_W-1];
    assign target_pos = !target_neg && (in_ch.target_speed != '0);
    assign flip       = (target_neg && dir_forward_reg) || (target_pos && !dir_forward_reg);
    assign diff       = flip ? '0 : pulse_count_reg - prior_count_reg;

    always_comb
    begin
        if (!target_neg)
        begin
            mag_next = in_ch.target_speed[SPEED_W-1:0];
        end
        else if (in_ch.target_speed[SPEED_W-1:0] == '0)
        begin
            mag_next = SPEED_MAX;
        end
        else
        begin
            mag_next = SPEED_W'(-in_ch.target_speed);
        end
    end

    assign speed_next = (sat_reg || (mac_acc > $signed(ACC_W'(SPEED_MAX))))
                        ? SPEED_MAX : mac_acc[SPEED_W-1:0];
    assign err_wide   = $signed({2'b00, mag_reg}) - $signed({2'b00, speed_next});
    assign err_next   = err_wide[ERR_W-1:0];
    assign sum_wide   = $signed({error_sum_reg[SUM_WIDTH-1], error_sum_reg})
                        + $signed({{(SUM_WIDTH+1-ERR_W){err_next[ERR_W-1]}}, err_next});

    always_comb
    begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
        begin
            sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_WIDTH-1:0];
        end
    end

    assign derr = $signed({prev_error_reg[ERR_W-1], prev_error_reg})
                  - $signed({err_reg[ERR_W-1], err_reg});

    assign acc_adj   = mac_acc + (mac_acc[ACC_W-1] ? $signed(FRAC_MASK) : $signed(ACC_W'(0)));
    assign acc_shift = acc_adj >>> GAIN_FRAC_BITS;

    always_comb
    begin
        if (delta_reg >= DELTA_HI)
        begin
            delta_clip = 10'sd256;
        end
        else if (delta_reg <= DELTA_LO)
        begin
            delta_clip = -10'sd256;
        end
        else
        begin
            delta_clip = delta_reg[9:0];
        end
        duty_sum = $signed({3'b000, duty_reg}) + $signed({delta_clip[9], delta_clip});
        if (duty_sum[10])
        begin
            duty_next = '0;
        end
        else if (duty_sum > 11'sd255)
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = duty_sum[DUTY_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        mac_cmd.load       = 1'b0;
        mac_cmd.clear_acc  = 1'b0;
        mac_cmd.operand    = '0;
        mac_cmd.multiplier = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (tick_fire)
                begin
                    mac_cmd.load       = 1'b1;
                    mac_cmd.clear_acc  = 1'b1;
                    mac_cmd.operand    = $signed({{(ACC_W-SPEED_W){1'b0}}, diff[SPEED_W-1:0]});
                    mac_cmd.multiplier = {{(GAIN_W-SCALE_W){1'b0}}, cfg.speed_scale};
                end
            end
            S_ERR:
            begin
                mac_cmd.load       = 1'b1;
                mac_cmd.clear_acc  = 1'b1;
                mac_cmd.operand    = $signed({{(ACC_W-ERR_W){err_next[ERR_W-1]}}, err_next});
                mac_cmd.multiplier = cfg.prop_gain;
            end
            S_PROP:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.load       = 1'b1;
                    mac_cmd.operand    = $signed({{(ACC_W-ERR_W-1){derr[ERR_W]}}, derr});
                    mac_cmd.multiplier = cfg.deriv_gain;
                end
            end
            S_DERIV:
            begin
                if (!mac_busy)
                begin
                    mac_cmd.load       = 1'b1;
                    mac_cmd.operand    = $signed({{(ACC_W-SUM_WIDTH){error_sum_reg[SUM_WIDTH-1]}},
                                                  error_sum_reg});
                    mac_cmd.multiplier = cfg.integ_gain;
                end
            end
            default:
            begin
                mac_cmd.load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (tick_fire) state_next = S_SPEED;
            S_SPEED: if (!mac_busy) state_next = S_ERR;
            S_ERR:   state_next = S_PROP;
            S_PROP:  if (!mac_busy) state_next = S_DERIV;
            S_DERIV: if (!mac_busy) state_next = S_INTEG;
            S_INTEG: if (!mac_busy) state_next = S_DELTA;
            S_DELTA: state_next = S_DUTY;
            S_DUTY:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pulse_count_reg <= '0;
            prior_count_reg <= '0;
            dir_forward_reg <= 1'b1;
            error_sum_reg   <= '0;
            prev_error_reg  <= '0;
            duty_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                case (in_ch.action)
                    ACT_PULSE:
                    begin
                        pulse_count_reg <= pulse_count_reg + 1'b1;
                    end
                    ACT_CLEAR:
                    begin
                        pulse_count_reg <= '0;
                        prior_count_reg <= '0;
                    end
                    ACT_TICK:
                    begin
                        if (flip)
                        begin
                            dir_forward_reg <= !dir_forward_reg;
                            pulse_count_reg <= '0;
                            prior_count_reg <= '0;
                            error_sum_reg   <= '0;
                            prev_error_reg  <= '0;
                        end
                        else
                        begin
                            prior_count_reg <= pulse_count_reg;
                        end
                    end
                    default:
                    begin
                        prior_count_reg <= prior_count_reg;
                    end
                endcase
            end
            if (state_reg == S_ERR)
            begin
                error_sum_reg <= sum_next;
            end
            if (state_reg == S_DELTA)
            begin
                prev_error_reg <= err_reg;
            end
            if (state_reg == S_DUTY && out_free)
            begin
                duty_reg      <= duty_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            mag_reg <= mag_next;
            sat_reg <= (diff[COUNT_W-1:SPEED_W] != '0) && (cfg.speed_scale != '0);
        end
        if (state_reg == S_ERR)
        begin
            speed_reg <= speed_next;
            err_reg   <= err_next;
        end
        if (state_reg == S_DELTA)
        begin
            delta_reg <= acc_shift[DELTA_W-1:0];
        end
        if (state_reg == S_DUTY && out_free)
        begin
            out_forward_reg <= dir_forward_reg;
            out_pwm_reg     <= (mag_reg != '0) ? duty_next : '0;
            out_speed_reg   <= speed_reg;
            out_error_reg   <= err_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.forward        = out_forward_reg;
    assign out_ch.drive_pwm      = out_pwm_reg;
    assign out_ch.measured_speed = out_speed_reg;
    assign out_ch.speed_error    = out_error_reg;

    // After a tick is taken the counter snapshot must match the live count.
    a_tick_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> (state_reg == S_SPEED) && (prior_count_reg == pulse_count_reg))
        else $error("tick did not snapshot the pulse count");

    // A result appears only from the final step of a tick.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DUTY))
        else $error("result raised outside the duty update step");

    // The multiplier must be finished whenever its accumulator is consumed.
    a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR || state_reg == S_DELTA || state_reg == S_DUTY) |-> !mac_busy)
        else $error("serial multiplier still running when its result is used");

endmodule

// ----- tb/tb_encoder_pid_motor_speed_controller_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for one encoder PID motor speed channel: directed rows, then
// randomized pulse and tick sequences under several gain settings, checked by a predictor.
// Depends on epid_pkg, epid_if and the top level encoder_pid_motor_speed_controller_top.
module tb_encoder_pid_motor_speed_controller_top import epid_pkg::*;;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_PCT     = 16;
    localparam int DIR_ROWS      = 21;
    localparam longint SUM_MAX   = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN   = -SUM_MAX - 1;

    typedef struct packed {
        logic                    forward;
        logic [DUTY_W-1:0]       drive_pwm;
        logic [SPEED_W-1:0]      measured_speed;
        logic signed [ERR_W-1:0] speed_error;
    } speed_res_t;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic signed [TARGET_W-1:0] target;
        logic                       typed;
        speed_res_t                 res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    epid_in_if  in_ch ();
    epid_out_if out_ch ();

    encoder_pid_motor_speed_controller_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [SCALE_W-1:0] pulse_scale;
    logic [COUNT_W-1:0] pulse_cnt;
    logic [COUNT_W-1:0] prior_cnt;
    logic               fwd_dir;
    longint             err_acc;
    longint             last_err;
    logic [DUTY_W-1:0]  duty_now;

    speed_res_t  loop_reports[$];
    int          err_cnt;
    bit          stall_on;
    bit          dir_neg;
    int unsigned cycle_cnt;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_PULSE,  -16'sd1,     1'b0, '0},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_TICK,   16'sd100,    1'b1, '{1'b1, 8'd0, 15'd3, 16'sd97}},
        '{ACT_TICK,   16'sd0,      1'b1, '{1'b1, 8'd0, 15'd0, 16'sd0}},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_TICK,   16'sh8000,   1'b1, '{1'b0, 8'd0, 15'd0, 16'sd32767}},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_UNUSED, -16'sd1,     1'b0, '0},
        '{ACT_CLEAR,  16'sh7FFF,   1'b0, '0},
        '{ACT_TICK,   -16'sd5,     1'b1, '{1'b0, 8'd0, 15'd0, 16'sd5}},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_TICK,   16'sd32767,  1'b1, '{1'b1, 8'd0, 15'd0, 16'sd32767}},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_TICK,   16'sd1,      1'b1, '{1'b1, 8'd0, 15'd1, 16'sd0}},
        '{ACT_TICK,   -16'sd32767, 1'b1, '{1'b0, 8'd0, 15'd0, 16'sd32767}},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_PULSE,  16'sd0,      1'b0, '0},
        '{ACT_TICK,   -16'sd1,     1'b1, '{1'b0, 8'd0, 15'd3, -16'sd2}}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit step_speed_loop(input logic [ACTION_W-1:0] act,
                                           input logic signed [TARGET_W-1:0] tgt,
                                           output speed_res_t res);
        longint             mag;
        longint             spd;
        longint             err;
        longint             acc;
        longint             duty_next;
        logic [COUNT_W-1:0] diff;
        res = '0;
        if (act == ACT_PULSE)
        begin
            pulse_cnt = pulse_cnt + 1'b1;
            return 1'b0;
        end
        if (act == ACT_CLEAR)
        begin
            pulse_cnt = '0;
            prior_cnt = '0;
            return 1'b0;
        end
        if (act != ACT_TICK)
            return 1'b0;
        if ((tgt < 0 && fwd_dir) || (tgt > 0 && !fwd_dir))
        begin
            fwd_dir   = (tgt > 0);
            pulse_cnt = '0;
            prior_cnt = '0;
            err_acc   = 0;
            last_err  = 0;
        end
        mag = (tgt < 0) ? -longint'(tgt) : longint'(tgt);
        if (mag > 32767)
            mag = 32767;
        diff = pulse_cnt - prior_cnt;
        spd = longint'(diff) * longint'(pulse_scale);
        if (spd > 32767)
            spd = 32767;
        prior_cnt = pulse_cnt;
        err = mag - spd;
        err_acc = err_acc + err;
        if (err_acc > SUM_MAX)
            err_acc = SUM_MAX;
        if (err_acc < SUM_MIN)
            err_acc = SUM_MIN;
        acc = longint'(kp_gain) * err - longint'(kd_gain) * (err - last_err)
            + longint'(ki_gain) * err_acc;
        last_err = err;
        duty_next = longint'(duty_now) + acc / (longint'(1) << GAIN_FRAC_BITS);
        if (duty_next < 0)
            duty_next = 0;
        if (duty_next > 255)
            duty_next = 255;
        duty_now = duty_next[DUTY_W-1:0];
        res.forward        = fwd_dir;
        res.drive_pwm      = (mag != 0) ? duty_now : '0;
        res.measured_speed = spd[SPEED_W-1:0];
        res.speed_error    = err[ERR_W-1:0];
        return 1'b1;
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  kp_gain     = data[GAIN_W-1:0];
            REG_INTEG_GAIN: ki_gain     = data[GAIN_W-1:0];
            REG_DERIV_GAIN: kd_gain     = data[GAIN_W-1:0];
            default:        pulse_scale = data[SCALE_W-1:0];
        endcase
    endtask

    task automatic set_loop_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                   input logic [GAIN_W-1:0] kd, input logic [SCALE_W-1:0] sc);
        apb_write(REG_PROP_GAIN, APB_DATA_W'(kp));
        apb_write(REG_INTEG_GAIN, APB_DATA_W'(ki));
        apb_write(REG_DERIV_GAIN, APB_DATA_W'(kd));
        apb_write(REG_SPEED_SCALE, APB_DATA_W'(sc));
    endtask

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic signed [TARGET_W-1:0] tgt,
                             input logic typed, input speed_res_t typed_res);
        speed_res_t pred;
        while (stall_on && $urandom_range(99) < STALL_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.target_speed <= tgt;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (step_speed_loop(act, tgt, pred))
            loop_reports.push_back(typed ? typed_res : pred);
    endtask

    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (loop_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(1023));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 6)
            return SCALE_W'($urandom_range(8, 1));
        return SCALE_W'($urandom_range(255, 1));
    endfunction

    function automatic logic signed [TARGET_W-1:0] pick_target(input bit neg);
        int roll;
        int mag;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            mag = 32767;
        else if (roll < 70)
            mag = $urandom_range(400, 1);
        else
            mag = $urandom_range(32767, 1);
        if (neg && mag == 32767 && $urandom_range(1) == 1)
            return 16'sh8000;
        return neg ? TARGET_W'(-mag) : TARGET_W'(mag);
    endfunction

    task automatic run_phase(input int budget, input bit sat_run);
        int                         sent;
        int                         burst;
        int                         roll;
        logic [ACTION_W-1:0]        act;
        logic signed [TARGET_W-1:0] noise;
        sent = 0;
        while (sent < budget)
        begin
            noise = TARGET_W'($urandom);
            roll  = $urandom_range(99);
            if (sat_run)
            begin
                send_item(ACT_TICK, dir_neg ? TARGET_W'(-32767) : TARGET_W'(32767), 1'b0, '0);
                sent++;
            end
            else if (roll < 80)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                    burst = $urandom_range(3);
                else if (roll < 95)
                    burst = $urandom_range(15, 4);
                else if (roll < 99)
                    burst = $urandom_range(40, 16);
                else
                    burst = $urandom_range(132, 129);
                repeat (burst)
                begin
                    send_item(ACT_PULSE, noise, 1'b0, '0);
                    noise = TARGET_W'($urandom);
                end
                if ($urandom_range(99) < 5)
                    dir_neg = !dir_neg;
                send_item(ACT_TICK, pick_target(dir_neg), 1'b0, '0);
                sent += burst + 1;
            end
            else if (roll < 88)
            begin
                send_item(ACT_CLEAR, noise, 1'b0, '0);
                sent++;
            end
            else if (roll < 94)
                send_item(ACT_UNUSED, noise, 1'b0, '0);
            else
            begin
                act = ACTION_W'($urandom_range(3));
                send_item(act, noise, 1'b0, '0);
                if (act != ACT_UNUSED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !stall_on || ($urandom_range(99) >= STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        speed_res_t want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (loop_reports.size() == 0)
            begin
                $display("%0t: result with no transaction pending: forward %0d pwm %0d speed %0d error %0d",
                         $time, out_ch.forward, out_ch.drive_pwm, out_ch.measured_speed,
                         out_ch.speed_error);
                err_cnt++;
            end
            else
            begin
                want = loop_reports.pop_front();
                if (out_ch.forward !== want.forward)
                begin
                    $display("%0t: forward expected %0d actual %0d",
                             $time, want.forward, out_ch.forward);
                    err_cnt++;
                end
                if (out_ch.drive_pwm !== want.drive_pwm)
                begin
                    $display("%0t: drive_pwm expected %0d actual %0d",
                             $time, want.drive_pwm, out_ch.drive_pwm);
                    err_cnt++;
                end
                if (out_ch.measured_speed !== want.measured_speed)
                begin
                    $display("%0t: measured_speed expected %0d actual %0d",
                             $time, want.measured_speed, out_ch.measured_speed);
                    err_cnt++;
                end
                if (out_ch.speed_error !== want.speed_error)
                begin
                    $display("%0t: speed_error expected %0d actual %0d",
                             $time, want.speed_error, out_ch.speed_error);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= ACT_PULSE;
        in_ch.target_speed <= '0;
        err_cnt     = 0;
        stall_on    = 1'b1;
        dir_neg     = 1'b0;
        kp_gain     = '0;
        ki_gain     = '0;
        kd_gain     = '0;
        pulse_scale = SCALE_RESET;
        pulse_cnt   = '0;
        prior_cnt   = '0;
        fwd_dir     = 1'b1;
        err_acc     = 0;
        last_err    = 0;
        duty_now    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].action, dir_tab[i].target, dir_tab[i].typed, dir_tab[i].res);
        settle_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       set_loop_config('1, '1, '1, '1);
                1:       set_loop_config('0, '0, '0, '0);
                2:       set_loop_config(16'd256, 16'd16, 16'd64, 8'd1);
                default: set_loop_config(pick_gain(), pick_gain(), pick_gain(), pick_scale());
            endcase
            stall_on = (ph != 5);
            run_phase((ph == 3) ? 270 : 90, ph == 3);
            settle_idle();
        end

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
